// ===== sv/sfp16_float_adder_unit_macros.svh =====
// Assertion macros for the sfp16 float adder checker.
// Used by the checker file only; no other dependencies.
`ifndef SFP16_FLOAT_ADDER_UNIT_MACROS_SVH
`define SFP16_FLOAT_ADDER_UNIT_MACROS_SVH

// implication checked on every clock, disabled in reset
`define SFA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SFA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/sfa_pkg.sv =====
// Package for the sfp16 float adder: constants and stage payload types.
// No dependencies.
`timescale 1ns / 1ps
package sfa_pkg;
  localparam logic [15:0] SignBit = 16'h8000;
  localparam logic [6:0]  ExpTop  = 7'h7f;

  // stage 1 -> stage 2 payload
  typedef struct packed {
    logic        done;     // result already final
    logic [15:0] res;
    logic        sign;
    logic        sub;
    logic [6:0]  ex;
    logic [11:0] mx;
    logic [11:0] my;
  } s1_t;

  // stage 2 -> stage 3 payload
  typedef struct packed {
    logic        done;
    logic [15:0] res;
    logic        sign;
    logic [7:0]  e;        // biased exponent after normalize
    logic [12:0] mx;       // 13-bit normalized value with sticky
  } s2_t;
endpackage

// ===== sv/sfp16_float_adder_unit.sv =====
// Top level of the sfp16 float adder: three register stages, the last one driving the outputs.
// Depends on sfa_pkg, sfa_align, sfa_norm, sfa_round.
`timescale 1ns / 1ps
// Adds two 16-bit floats (sign, 7-bit exponent, 8-bit fraction, subnormals),
// rounding to nearest even. Fully pipelined: one request per cycle unless the
// output stalls. There are three register stages: align, add/normalize, round,
// each closed by a register. The result passes through all three before it
// shows on the outputs.
// The whole pipe advances when the output register is empty or being taken,
// so no request is lost under stalls; throughput is one request per cycle while it advances.
module sfp16_float_adder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] operand_a_i,
  input  logic [15:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] sum_o
);
  sfa_pkg::s1_t s1_d, s1_q;
  sfa_pkg::s2_t s2_d, s2_q;
  logic [15:0]  r_d, r_q;
  logic         v1_q, v2_q, v3_q;
  logic         adv;

  // pipe moves when the last stage is free or being drained
  assign adv        = !v3_q || out_ready_i;
  assign in_ready_o = adv;

  sfa_align u_align (.a_i(operand_a_i), .b_i(operand_b_i), .s_o(s1_d));
  sfa_norm  u_norm  (.s_i(s1_q), .s_o(s2_d));
  sfa_round u_round (.s_i(s2_q), .res_o(r_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      r_q  <= r_d;
    end
  end

  assign out_valid_o = v3_q;
  assign sum_o       = r_q;
endmodule

// ===== sv/sfa_align.sv =====
// Stage 1: order operands, handle specials, align smaller significand.
// Depends on sfa_pkg.
`timescale 1ns / 1ps
module sfa_align (
  input  logic [15:0]   a_i,
  input  logic [15:0]   b_i,
  output sfa_pkg::s1_t  s_o
);
  logic [15:0] x, y;
  logic [6:0]  ex, ey;
  logic [7:0]  d;
  logic [11:0] fy;
  logic [11:0] lostm;

  always_comb begin
    x = a_i; y = b_i;
    if (a_i[14:0] < b_i[14:0]) begin
      x = b_i; y = a_i;
    end
    ex = x[14:8]; ey = y[14:8];
    s_o = '0;
    s_o.sign = x[15];
    s_o.sub  = x[15] != y[15];
    s_o.ex   = ex;
    s_o.mx   = {(ex != 7'd0), x[7:0], 3'b000};
    fy       = {(ey != 7'd0), y[7:0], 3'b000};
    d = 8'd0;
    if (ex == sfa_pkg::ExpTop) begin
      s_o.done = 1'b1;
      if (x != y && ey == sfa_pkg::ExpTop) s_o.res = {x[15], 15'h7f01};
      else s_o.res = {x[15:8], 7'd0, (x[7:0] != 8'd0)};
    end else if (ex != 7'd0) begin
      d = {1'b0, ex} - {1'b0, ey};
      if (d > 8'd11) begin
        s_o.done = 1'b1;
        s_o.res  = x;
      end
      if (ey == 7'd0) d = d - 8'd1;
    end
    if (d > 8'd11) d = 8'd12;
    lostm = (12'd1 << d[3:0]) - 12'd1;
    s_o.my = (fy >> d[3:0]) | {11'd0, ((fy & lostm) != 12'd0)};
  end
endmodule

// ===== sv/sfa_norm.sv =====
// Stage 2: add or subtract, then normalize.
// Depends on sfa_pkg.
`timescale 1ns / 1ps
module sfa_norm (
  input  sfa_pkg::s1_t s_i,
  output sfa_pkg::s2_t s_o
);
  logic [12:0] m;
  logic [3:0]  lz;
  logic signed [8:0] e;
  logic [3:0]  sh;

  always_comb begin
    s_o = '0;
    s_o.done = s_i.done;
    s_o.res  = s_i.res;
    s_o.sign = s_i.sign;
    m = '0; lz = '0; sh = '0;
    e = $signed({2'b00, s_i.ex});
    if (!s_i.sub) m = {1'b0, s_i.mx} + {1'b0, s_i.my};
    else if (s_i.mx > s_i.my) m = {1'b0, s_i.mx - s_i.my};
    else if (!s_i.done) begin
      s_o.done = 1'b1;
      s_o.res  = {s_i.sign, 15'd0};
    end
    if (m[12]) begin
      m = {1'b0, m[12:2], m[1] | m[0]};
      e = e + 9'sd1;
    end else if (e != 9'sd0) begin
      lz = 4'd12;
      for (int i = 11; i >= 0; i--) begin
        if (m[i] && lz == 4'd12) lz = 4'(11 - i);
      end
      e = e - $signed({5'd0, lz});
      m = m << lz;
      if (e <= 9'sd0) begin
        sh = 4'(9'sd1 - e);
        m = m >> sh;
        e = 9'sd0;
      end
    end else if (m[11]) begin
      e = 9'sd1;
    end
    s_o.mx = m;
    s_o.e  = e[7:0];
  end
endmodule

// ===== sv/sfa_round.sv =====
// Stage 3: round to nearest even, pack result.
// Depends on sfa_pkg.
`timescale 1ns / 1ps
module sfa_round (
  input  sfa_pkg::s2_t s_i,
  output logic [15:0]  res_o
);
  logic [11:0] m;
  logic [7:0]  e;

  always_comb begin
    e = s_i.e;
    m = {1'b0, s_i.mx[11:1]} | {11'd0, s_i.mx[0]};
    if (m[1] && (m[2] || m[0])) m = m + 12'd2;
    if (m[11]) begin
      m = '0;
      e = e + 8'd1;
    end else if (e == 8'd0 && m[10]) begin
      e = 8'd1;
    end
    if (s_i.done) res_o = s_i.res;
    else if (e >= {1'b0, sfa_pkg::ExpTop}) res_o = {s_i.sign, 15'h7f00};
    else res_o = {s_i.sign, e[6:0], m[9:2]};
  end
endmodule

// ===== sv/sfa_checker.sv =====
// Port-level checker for the sfp16 float adder, bound to the top level.
// Depends on sfp16_float_adder_unit_macros.svh.
`timescale 1ns / 1ps
`include "sfp16_float_adder_unit_macros.svh"
module sfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] sum_o
);
  `SFA_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(sum_o))
  `SFA_ASSERT_IMP(a_ready, clk_i, rst_ni, !out_valid_o, in_ready_o)
  `SFA_ASSERT_IMP(a_flow, clk_i, rst_ni, out_ready_i, in_ready_o)
endmodule

bind sfp16_float_adder_unit sfa_checker u_sfa_checker (.*);
